/* sv/dpm_pkg.sv */
// Shared types, codes and constants for the Magnus dew point block.
// No dependencies; dew_point_magnus, dpm_checker and the testbench refer to it by scoped names.

package dpm_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Register index as decoded from paddr[2]
    localparam logic REG_IDX_A = 1'b0;
    localparam logic REG_IDX_B = 1'b1;

    localparam logic [14:0] A_RESET = 15'd17271;
    localparam logic [14:0] B_RESET = 15'd23770;

    localparam logic signed [14:0] DEW_MIN = -15'sd15000;
    localparam logic signed [14:0] DEW_MAX = 15'sd8000;

    // ln(2) and ln(10000) in Q30
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [63:0] LN10000_Q30 = 64'd9889527671;

    // How a reading is handled before the last division
    typedef enum logic [1:0] {
        CASE_NORM,
        CASE_ZERO,
        CASE_LOWDEN
    } t_case;

    // log2(1 + i/2^lb) in Q(fb), by 30 rounds of bitwise squaring in Q30
    function automatic logic [63:0] log_entry(input int i, input int lb, input int fb);
        logic [63:0] x;
        logic [63:0] r;
        x = (64'd1 << 30) + (64'(i) << (30 - lb));
        r = 64'd0;
        for (int k = 0; k < 30; k++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                r = r | 64'd1;
            end
        end
        return (r + (64'd1 << (29 - fb))) >> (30 - fb);
    endfunction

endpackage

/* sv/dpm_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Uses no package; instantiated by dew_point_magnus.

module dpm_div #(
    parameter int NW = 46,
    parameter int DW = 26,
    parameter int QW = 36,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    // Requires i_num < i_den * 2^QW for a meaningful quotient.
    logic [QW:0]   r_v;
    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_d   [QW];
    logic [QW-1:0] r_lq  [QW+1];
    logic [SW-1:0] r_sd  [QW+1];

    logic [DW:0]   w_tr [QW];
    logic [DW:0]   w_df [QW];
    logic          w_ge [QW];
    logic [DW-1:0] w_nr [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_tr[k] = {r_rem[k], r_lq[k][QW-1]};
            w_df[k] = w_tr[k] - {1'b0, r_d[k]};
            w_ge[k] = (w_tr[k] >= {1'b0, r_d[k]});
            w_nr[k] = w_ge[k] ? w_df[k][DW-1:0] : w_tr[k][DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num >> QW);
            r_d[0]   <= i_den;
            r_lq[0]  <= i_num[QW-1:0];
            r_sd[0]  <= i_side;
            for (int k = 0; k < QW; k++) begin
                r_lq[k+1] <= {r_lq[k][QW-2:0], w_ge[k]};
                r_sd[k+1] <= r_sd[k];
            end
            for (int k = 1; k < QW; k++) begin
                r_rem[k] <= w_nr[k-1];
                r_d[k]   <= r_d[k-1];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quot  = r_lq[QW];
    assign o_side  = r_sd[QW];

endmodule

/* sv/dew_point_magnus.sv */
// Top level of the Magnus dew point block: config registers, log, pipeline.
// Depends on dpm_pkg and dpm_div.

// Takes one reading (temperature in 0.01 C, signed; relative humidity in
// 0.01 %) per beat and returns one dew point in 0.01 C with a status code:
// ok, humidity zero (dew point 0) or saturated (clamped to -150.00 or
// +80.00 C). The pipeline accepts a new reading every cycle while no result
// stall holds it; a reading passes FRAC_BITS + 47 register stages: the two
// pipelined dividers, a*T/(b+T) with FRAC_BITS+21 stages and b*gamma/(a-gamma)
// with 16 stages, nine more for the log path, products and clamps, plus the
// output register. A result beat held by a stall freezes the whole pipeline; a
// one-entry skid at the input absorbs the beat that arrives as the stall takes
// hold, so o_stall is a register. Coefficients a (x1000) and b (0.01 C) sit at
// APB byte addresses 0 and 4 and must be written only while the block is idle.

module dew_point_magnus #(
    parameter int LOG_TABLE_BITS = 6,
    parameter int FRAC_BITS      = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // reading channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [13:0] i_temperature,
    input  logic        [13:0] i_humidity,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_td,
    output logic        [1:0]  o_status,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    localparam int F   = FRAC_BITS;
    localparam int L   = LOG_TABLE_BITS;
    localparam int RW  = 16 - L;        // interpolation fraction bits
    localparam int LW  = F + 4;         // log2 / ln magnitude width
    localparam int NW1 = F + 30;        // a*|T|*2^F + d/2
    localparam int DW1 = 26;            // 1000*(b+T)
    localparam int QW1 = F + 20;
    localparam int SW1 = F + 8;
    localparam int GW  = F + 22;        // gamma, signed
    localparam int MW  = F + 20;        // |gamma|
    localparam int PW  = F + 33;        // a*2^F - 1000*gamma, signed
    localparam int DW2 = F + 23;
    localparam int NW2 = F + 46;
    localparam int QW2 = 15;
    localparam int SPL = 22;            // split point of |gamma| for the product

    localparam logic [LW-1:0] LNC =
        LW'((dpm_pkg::LN10000_Q30 + (64'd1 << (29 - F))) >> (30 - F));
    localparam logic signed [GW-1:0] GMIN = -(GW'(1) <<< (F + 12));

    // ---------------- configuration ----------------
    logic [14:0] r_a;
    logic [14:0] r_b;
    logic [24:0] r_b1000;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= dpm_pkg::A_RESET;
            r_b <= dpm_pkg::B_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == dpm_pkg::REG_IDX_A) begin
                r_a <= pwdata[14:0];
            end else begin
                r_b <= pwdata[14:0];
            end
        end
    end

    // b must stay static while items run (the block does not enforce it); keep b*1000 ready for the last product
    always_ff @(posedge i_clk) begin
        r_b1000 <= 25'(r_b) * 25'd1000;
    end

    always_comb begin
        if (paddr[2] == dpm_pkg::REG_IDX_B) begin
            prdata = {17'd0, r_b};
        end else begin
            prdata = {17'd0, r_a};
        end
    end

    // ---------------- flow control ----------------
    logic w_en;
    logic r_out_v;
    assign w_en = !(r_out_v && i_stall);

    // input skid: catch the beat accepted while the pipeline holds
    logic               r_sk_v;
    logic signed [13:0] r_sk_t;
    logic        [13:0] r_sk_h;
    logic               w_v0;
    logic signed [13:0] w_t0;
    logic        [13:0] w_h0;

    assign o_stall = r_sk_v;
    assign w_v0    = r_sk_v || i_valid;
    assign w_t0    = r_sk_v ? r_sk_t : i_temperature;
    assign w_h0    = r_sk_v ? r_sk_h : i_humidity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (w_en) begin
            r_sk_v <= 1'b0;
        end else if (i_valid && !r_sk_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && i_valid && !r_sk_v) begin
            r_sk_t <= i_temperature;
            r_sk_h <= i_humidity;
        end
    end

    // ---------------- stage 1: classify, a*|T|, normalize humidity ----------------
    logic               w_tneg;
    logic [13:0]        w_tmag;
    logic signed [16:0] w_den1;
    logic [28:0]        w_m1;
    logic [3:0]         w_p;
    logic [13:0]        w_hm;
    logic [29:0]        w_sh;
    dpm_pkg::t_case     w_case0;

    assign w_tneg = w_t0[13];
    assign w_tmag = w_tneg ? 14'(-w_t0) : 14'(w_t0);
    assign w_den1 = $signed({2'b00, r_b}) + 17'(w_t0);
    assign w_m1   = 29'(r_a) * 29'(w_tmag);

    // leading one of the humidity
    always_comb begin
        w_p = 4'd0;
        for (int i = 1; i < 14; i++) begin
            if (w_h0[i]) begin
                w_p = 4'(i);
            end
        end
    end

    assign w_hm = w_h0 & ~(14'd1 << w_p);
    assign w_sh = {w_hm, 16'd0} >> w_p;

    always_comb begin
        if (w_h0 == 14'd0) begin
            w_case0 = dpm_pkg::CASE_ZERO;
        end else if (w_den1 <= 17'sd0) begin
            w_case0 = dpm_pkg::CASE_LOWDEN;
        end else begin
            w_case0 = dpm_pkg::CASE_NORM;
        end
    end

    logic           r1_v;
    dpm_pkg::t_case r1_case;
    logic           r1_tneg;
    logic [28:0]    r1_m1;
    logic [15:0]    r1_den1;
    logic [3:0]     r1_p;
    logic [15:0]    r1_fr;

    // ---------------- stage 2: divisor, numerator, table read ----------------
    logic [F:0]   w_tab [2**L+1];
    logic [L:0]   w_i0;
    logic [L:0]   w_i1;
    logic [DW1-1:0] w_d1;

    for (genvar gi = 0; gi <= 2**L; gi++) begin : g_tab
        assign w_tab[gi] = (F+1)'(dpm_pkg::log_entry(gi, L, F));
    end

    assign w_i0 = {1'b0, r1_fr[15:RW]};
    assign w_i1 = w_i0 + (L+1)'(1);
    assign w_d1 = DW1'(r1_den1) * DW1'(1000);

    logic           r2_v;
    dpm_pkg::t_case r2_case;
    logic           r2_tneg;
    logic [NW1-1:0] r2_num1;
    logic [DW1-1:0] r2_d1;
    logic [3:0]     r2_p;
    logic [F:0]     r2_e0;
    logic [F:0]     r2_df;
    logic [RW-1:0]  r2_rem;

    // ---------------- stage 3: interpolate log2 ----------------
    logic [F+RW:0]  w_ip;
    assign w_ip = (F+RW+1)'(r2_df) * (F+RW+1)'(r2_rem);

    logic           r3_v;
    dpm_pkg::t_case r3_case;
    logic           r3_tneg;
    logic [NW1-1:0] r3_num1;
    logic [DW1-1:0] r3_d1;
    logic [LW-1:0]  r3_l2;

    // ---------------- stage 4: times ln2 ----------------
    logic           r4_v;
    dpm_pkg::t_case r4_case;
    logic           r4_tneg;
    logic [NW1-1:0] r4_num1;
    logic [DW1-1:0] r4_d1;
    logic [LW+29:0] r4_lp;

    logic [LW+29:0]       w_lr;
    logic [LW-1:0]        w_ln;
    logic signed [LW:0]   w_lnrh;

    assign w_lr   = r4_lp + ((LW+30)'(1) << 29);
    assign w_ln   = w_lr[LW+29:30];
    assign w_lnrh = $signed({1'b0, w_ln}) - $signed({1'b0, LNC});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_v0;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_case <= w_case0;
            r1_tneg <= w_tneg;
            r1_m1   <= w_m1;
            r1_den1 <= w_den1[15:0];
            r1_p    <= w_p;
            r1_fr   <= w_sh[15:0];

            r2_case <= r1_case;
            r2_tneg <= r1_tneg;
            r2_num1 <= (NW1'(r1_m1) << F) + NW1'(w_d1 >> 1);
            r2_d1   <= w_d1;
            r2_p    <= r1_p;
            r2_e0   <= w_tab[w_i0];
            r2_df   <= w_tab[w_i1] - w_tab[w_i0];
            r2_rem  <= r1_fr[RW-1:0];

            r3_case <= r2_case;
            r3_tneg <= r2_tneg;
            r3_num1 <= r2_num1;
            r3_d1   <= r2_d1;
            r3_l2   <= (LW'(r2_p) << F) + LW'(r2_e0) + LW'(w_ip[F+RW:RW]);

            r4_case <= r3_case;
            r4_tneg <= r3_tneg;
            r4_num1 <= r3_num1;
            r4_d1   <= r3_d1;
            r4_lp   <= (LW+30)'(r3_l2) * (LW+30)'(dpm_pkg::LN2_Q30);
        end
    end

    // ---------------- divider 1: a*T*2^F / (1000*(b+T)) ----------------
    logic           w_q1_v;
    logic [QW1-1:0] w_q1;
    logic [SW1-1:0] w_s1;

    dpm_div #(
        .NW (NW1),
        .DW (DW1),
        .QW (QW1),
        .SW (SW1)
    ) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_num   (r4_num1),
        .i_den   (r4_d1),
        .i_side  ({r4_case, r4_tneg, w_lnrh}),
        .o_valid (w_q1_v),
        .o_quot  (w_q1),
        .o_side  (w_s1)
    );

    logic               w_s1_tneg;
    logic signed [LW:0] w_s1_lnrh;
    assign w_s1_tneg = w_s1[LW+1];
    assign w_s1_lnrh = $signed(w_s1[LW:0]);

    // ---------------- stage G: gamma = term1 + ln(RH/100) ----------------
    logic                  rg_v;
    dpm_pkg::t_case        rg_case;
    logic signed [GW-1:0]  rg_g;

    // ---------------- stage H: clamp gamma, magnitude ----------------
    logic                  rh_v;
    dpm_pkg::t_case        rh_case;
    logic signed [GW-1:0]  rh_g;
    logic                  rh_gneg;
    logic [MW-1:0]         rh_gmag;

    // ---------------- stage I: second divisor, partial products ----------------
    logic                  ri_v;
    dpm_pkg::t_case        ri_case;
    logic                  ri_gneg;
    logic signed [PW-1:0]  ri_d2;
    logic [46:0]           ri_plo;
    logic [F+22:0]         ri_phi;

    // ---------------- stage J: sum products ----------------
    logic                  rj_v;
    dpm_pkg::t_case        rj_case;
    logic                  rj_gneg;
    logic                  rj_d2bad;
    logic [DW2-1:0]        rj_d2;
    logic [NW2-2:0]        rj_m2;

    // ---------------- stage K: add half divisor ----------------
    logic                  rk_v;
    dpm_pkg::t_case        rk_case;
    logic                  rk_gneg;
    logic                  rk_d2bad;
    logic [DW2-1:0]        rk_d2;
    logic [NW2-1:0]        rk_num2;

    logic                  w_ovf;
    assign w_ovf = (rk_num2 >> QW2) >= NW2'(rk_d2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rg_v <= 1'b0;
            rh_v <= 1'b0;
            ri_v <= 1'b0;
            rj_v <= 1'b0;
            rk_v <= 1'b0;
        end else if (w_en) begin
            rg_v <= w_q1_v;
            rh_v <= rg_v;
            ri_v <= rh_v;
            rj_v <= ri_v;
            rk_v <= rj_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rg_case <= dpm_pkg::t_case'(w_s1[LW+3:LW+2]);
            if (w_s1_tneg) begin
                rg_g <= GW'(w_s1_lnrh) - $signed({2'b00, w_q1});
            end else begin
                rg_g <= GW'(w_s1_lnrh) + $signed({2'b00, w_q1});
            end

            rh_case <= rg_case;
            rh_gneg <= rg_g[GW-1];
            if (rg_g < GMIN) begin
                rh_g    <= GMIN;
                rh_gmag <= MW'(1) << (F + 12);
            end else begin
                rh_g    <= rg_g;
                rh_gmag <= rg_g[GW-1] ? MW'(-rg_g) : MW'(rg_g);
            end

            ri_case <= rh_case;
            ri_gneg <= rh_gneg;
            ri_d2   <= (PW'(r_a) <<< F) - PW'(rh_g) * PW'(1000);
            ri_plo  <= 47'(r_b1000) * 47'(rh_gmag[SPL-1:0]);
            ri_phi  <= (F+23)'(r_b1000) * (F+23)'(rh_gmag[MW-1:SPL]);

            rj_case  <= ri_case;
            rj_gneg  <= ri_gneg;
            rj_d2bad <= (ri_d2 <= PW'(0));
            rj_d2    <= ri_d2[DW2-1:0];
            rj_m2    <= ((NW2-1)'(ri_phi) << SPL) + (NW2-1)'(ri_plo);

            rk_case  <= rj_case;
            rk_gneg  <= rj_gneg;
            rk_d2bad <= rj_d2bad;
            rk_d2    <= rj_d2;
            rk_num2  <= NW2'(rj_m2) + NW2'(rj_d2 >> 1);
        end
    end

    // ---------------- divider 2: 1000*b*gamma / (a*2^F - 1000*gamma) ----------------
    logic           w_q2_v;
    logic [QW2-1:0] w_q2;
    logic [4:0]     w_s2;

    dpm_div #(
        .NW (NW2),
        .DW (DW2),
        .QW (QW2),
        .SW (5)
    ) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rk_v),
        .i_num   (rk_num2),
        .i_den   (rk_d2),
        .i_side  ({rk_case, rk_d2bad, w_ovf, rk_gneg}),
        .o_valid (w_q2_v),
        .o_quot  (w_q2),
        .o_side  (w_s2)
    );

    // ---------------- sign, clamp, status ----------------
    dpm_pkg::t_case     w_fc;
    logic signed [14:0] w_dp;
    logic [1:0]         w_st;

    assign w_fc = dpm_pkg::t_case'(w_s2[4:3]);

    always_comb begin
        w_dp = 15'sd0;
        w_st = dpm_pkg::ST_OK;
        case (w_fc)
            dpm_pkg::CASE_ZERO: begin
                w_dp = 15'sd0;
                w_st = dpm_pkg::ST_ZERO;
            end
            dpm_pkg::CASE_LOWDEN: begin
                w_dp = dpm_pkg::DEW_MIN;
                w_st = dpm_pkg::ST_SAT;
            end
            dpm_pkg::CASE_NORM: begin
                if (w_s2[2]) begin
                    // a - gamma not positive
                    w_dp = dpm_pkg::DEW_MAX;
                    w_st = dpm_pkg::ST_SAT;
                end else if (w_s2[1]) begin
                    w_dp = w_s2[0] ? dpm_pkg::DEW_MIN : dpm_pkg::DEW_MAX;
                    w_st = dpm_pkg::ST_SAT;
                end else if (w_s2[0]) begin
                    if (w_q2 > 15'd15000) begin
                        w_dp = dpm_pkg::DEW_MIN;
                        w_st = dpm_pkg::ST_SAT;
                    end else begin
                        w_dp = -$signed(w_q2);
                    end
                end else begin
                    if (w_q2 > 15'd8000) begin
                        w_dp = dpm_pkg::DEW_MAX;
                        w_st = dpm_pkg::ST_SAT;
                    end else begin
                        w_dp = $signed(w_q2);
                    end
                end
            end
            default: begin
                w_dp = 15'sd0;
                w_st = dpm_pkg::ST_OK;
            end
        endcase
    end

    // output register: hold while stalled
    logic signed [14:0] r_out_dp;
    logic [1:0]         r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_q2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_dp <= w_dp;
            r_out_st <= w_st;
        end
    end

    assign o_valid  = r_out_v;
    assign o_td     = r_out_dp;
    assign o_status = r_out_st;

endmodule

/* sv/dpm_checker.sv */
// Port-level checks on the result channel of dew_point_magnus, and its bind.
// Depends on dpm_pkg.

module dpm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [14:0] o_td,
    input logic        [1:0]  o_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_td) && $stable(o_status))
        else $error("stalled result beat changed");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == dpm_pkg::ST_ZERO |-> o_td == 15'sd0)
        else $error("zero-humidity beat with nonzero dew point");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_td >= dpm_pkg::DEW_MIN && o_td <= dpm_pkg::DEW_MAX)
        else $error("dew point out of range");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == dpm_pkg::ST_SAT |->
            o_td == dpm_pkg::DEW_MIN || o_td == dpm_pkg::DEW_MAX)
        else $error("saturated beat not at a bound");

endmodule

bind dew_point_magnus dpm_checker u_dpm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_td     (o_td),
    .o_status (o_status)
);

/* tb/dew_point_magnus_test.sv */
// Self-checking testbench for the Magnus dew point block.
// Holds its own fixed-point dew point predictor; needs only dpm_pkg and the RTL.
`timescale 1ns / 100ps

module dew_point_magnus_test;

    localparam int TBL_BITS = 6;
    localparam int QBITS    = 16;
    localparam int LATENCY  = 70;   // covers the pipeline plus skid and margin

    typedef struct {
        logic signed [13:0] temp;
        logic        [13:0] hum;
        bit                 typed;
        logic signed [14:0] dew;
        logic        [1:0]  st;
    } t_reading_row;

    typedef struct {
        logic signed [14:0] dew;
        logic        [1:0]  st;
    } t_dew_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [13:0] i_temperature = '0;
    logic        [13:0] i_humidity = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [14:0] o_td;
    logic        [1:0]  o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic        [2:0]  paddr = '0;
    logic        [31:0] pwdata = '0;
    logic        [31:0] prdata;
    logic               pready;

    dew_point_magnus i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state: coefficient copies and the log2 table
    logic [14:0] coef_a = dpm_pkg::A_RESET;
    logic [14:0] coef_b = dpm_pkg::B_RESET;
    logic [63:0] log2_tbl [0:(1 << TBL_BITS)];

    t_dew_result dew_pending[$];
    int          errors = 0;
    int          beats_in = 0;

    // Typed expectation riding along with the beat currently offered
    bit                 cur_typed = 1'b0;
    logic signed [14:0] cur_dew = '0;
    logic        [1:0]  cur_st = dpm_pkg::ST_OK;

    task automatic report(input string what);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Bitwise squaring: 30 result bits of log2(1 + i/2^TBL_BITS) in Q30, rounded to Q16
    function automatic logic [63:0] log2_frac(input int i);
        logic [63:0] x, acc;
        x = (64'd1 << 30) + (64'(i) << (30 - TBL_BITS));
        acc = '0;
        for (int k = 0; k < 30; k++) begin
            x = (x * x) >> 30;
            acc = acc << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                acc = acc | 64'd1;
            end
        end
        return (acc + (64'd1 << (29 - QBITS))) >> (30 - QBITS);
    endfunction

    // Natural log of h (1..16383) in Q16, table plus truncating interpolation
    function automatic logic [63:0] ln_q(input logic [13:0] h);
        int          p;
        logic [63:0] fr, idx, rem, e0, e1, l2;
        p = 13;
        while (p > 0 && h[p] == 1'b0)
            p--;
        fr  = ((64'(h) - (64'd1 << p)) << 16) >> p;
        idx = fr >> (16 - TBL_BITS);
        rem = fr & ((64'd1 << (16 - TBL_BITS)) - 1);
        e0  = log2_tbl[idx];
        e1  = log2_tbl[idx + 1];
        l2  = (64'(p) << QBITS) + e0 + (((e1 - e0) * rem) >> (16 - TBL_BITS));
        return (l2 * 64'(dpm_pkg::LN2_Q30) + (64'd1 << 29)) >> 30;
    endfunction

    // Round to nearest, ties away from zero; d > 0
    function automatic longint round_div(input longint n, input longint d);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m + d / 2) / d;
        return (n < 0) ? -m : m;
    endfunction

    function automatic t_dew_result dew_predict(input logic signed [13:0] t_in,
                                                input logic [13:0] h);
        t_dew_result r;
        longint      t, a, b, den1, term1, lnrh, g, den2, td;
        t = t_in;
        a = coef_a;
        b = coef_b;
        r.st = dpm_pkg::ST_OK;
        if (h == 0) begin
            r.dew = '0;
            r.st  = dpm_pkg::ST_ZERO;
            return r;
        end
        den1 = b + t;
        if (den1 <= 0) begin
            td = dpm_pkg::DEW_MIN;
            r.st = dpm_pkg::ST_SAT;
        end else begin
            term1 = round_div(a * t * (64'sd1 << QBITS), 1000 * den1);
            lnrh  = longint'(ln_q(h))
                  - longint'((dpm_pkg::LN10000_Q30 + (64'd1 << (29 - QBITS)))
                             >> (30 - QBITS));
            g = term1 + lnrh;
            if (g < -(64'sd1 << (QBITS + 12)))
                g = -(64'sd1 << (QBITS + 12));
            den2 = a * (64'sd1 << QBITS) - 1000 * g;
            if (den2 <= 0) begin
                td = dpm_pkg::DEW_MAX;
                r.st = dpm_pkg::ST_SAT;
            end else begin
                td = round_div(b * 1000 * g, den2);
                if (td < dpm_pkg::DEW_MIN) begin
                    td = dpm_pkg::DEW_MIN;
                    r.st = dpm_pkg::ST_SAT;
                end else if (td > dpm_pkg::DEW_MAX) begin
                    td = dpm_pkg::DEW_MAX;
                    r.st = dpm_pkg::ST_SAT;
                end
            end
        end
        r.dew = td[14:0];
        return r;
    endfunction

    // Monitor: queue a prediction per accepted reading, check each result beat
    always @(posedge i_clk) begin
        t_dew_result e, p;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                p = dew_predict(i_temperature, i_humidity);
                if (cur_typed) begin
                    p.dew = cur_dew;
                    p.st  = cur_st;
                end
                dew_pending.push_back(p);
                beats_in++;
            end
            if (o_valid && !i_stall) begin
                if (dew_pending.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    e = dew_pending.pop_front();
                    if (o_td !== e.dew)
                        report($sformatf("dew point %0d, expected %0d", o_td, e.dew));
                    if (o_status !== e.st)
                        report($sformatf("status %0d, expected %0d", o_status, e.st));
                end
            end
        end
    end

    // Offer one reading and hold it until the block takes it
    task automatic put_reading(input t_reading_row row);
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_temperature = row.temp;
        i_humidity    = row.hum;
        cur_typed     = row.typed;
        cur_dew       = row.dew;
        cur_st        = row.st;
        // o_stall only moves at a rising edge, so its value now is what the next edge sees
        while (o_stall)
            @(negedge i_clk);
    endtask

    task automatic drop_valid(input int cycles);
        @(negedge i_clk);
        i_valid   = 1'b0;
        cur_typed = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Hold until every expected result is back, then let the pipe empty
    task automatic drain();
        drop_valid(1);
        while (dew_pending.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr[2] == dpm_pkg::REG_IDX_A)
            coef_a = data[14:0];
        else
            coef_b = data[14:0];
    endtask

    function automatic t_reading_row random_reading();
        t_reading_row r;
        int           tsel, near_t;
        tsel = $urandom_range(0, 9);
        if (tsel < 3) begin
            r.temp = 14'($urandom);
        end else if (tsel < 8) begin
            r.temp = 14'($urandom_range(0, 12000)) - 14'sd4000;
        end else begin
            // Near the pole of a*T/(b+T): b+T small, zero or negative
            near_t = -int'(coef_b) + $urandom_range(0, 6) - 3;
            if (near_t < -8192 || near_t > 8191)
                near_t = -8192 + $urandom_range(0, 3);
            r.temp = 14'(near_t);
        end
        case ($urandom_range(0, 19))
            0:       r.hum = '0;
            1, 2:    r.hum = 14'($urandom_range(1, 20));
            3, 4, 5: r.hum = 14'($urandom);
            default: r.hum = 14'($urandom_range(1, 10000));
        endcase
        r.typed = 1'b0;
        r.dew   = '0;
        r.st    = dpm_pkg::ST_OK;
        return r;
    endfunction

    // Receiver: one long hold-off to fill the pipe, then a shifting stall pattern
    initial begin
        int mode, len;
        i_stall = 1'b0;
        while (beats_in < 40)
            @(negedge i_clk);
        i_stall = 1'b1;
        repeat (200) @(negedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 200);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_stall = 1'b0;
                    1:       i_stall = ($urandom_range(0, 3) == 0);
                    2:       i_stall = ($urandom_range(0, 9) < 7);
                    default: i_stall = (len > 60);
                endcase
            end
        end
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_reading_row dir_rows [18];
        logic [14:0]  phase_a [8];
        logic [14:0]  phase_b [8];
        int           burst;

        for (int i = 0; i <= (1 << TBL_BITS); i++)
            log2_tbl[i] = log2_frac(i);

        // Humidity-zero rows have an obvious answer; the rest go to the predictor
        dir_rows = '{
            '{14'sd0,     14'd0,     1'b1, 15'sd0, dpm_pkg::ST_ZERO},
            '{14'sd8191,  14'd0,     1'b1, 15'sd0, dpm_pkg::ST_ZERO},
            '{-14'sd8192, 14'd0,     1'b1, 15'sd0, dpm_pkg::ST_ZERO},
            '{-14'sd4000, 14'd10000, 1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd8000,  14'd10000, 1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd0,     14'd10000, 1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd2500,  14'd5000,  1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{-14'sd4000, 14'd1,     1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd8000,  14'd1,     1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd8191,  14'd16383, 1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{-14'sd8192, 14'd16383, 1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{-14'sd8192, 14'd1,     1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd0,     14'd1,     1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd2000,  14'd10001, 1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd1234,  14'd8192,  1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{-14'sd1,    14'd8191,  1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd1,     14'd4096,  1'b0, 15'sd0, dpm_pkg::ST_OK},
            '{14'sd3000,  14'd16383, 1'b0, 15'sd0, dpm_pkg::ST_OK}
        };

        // Reset values, range extremes, b of zero (a-gamma hits zero),
        // a of zero, b just above the lowest temperature (gamma clamp), then two random pairs
        phase_a = '{dpm_pkg::A_RESET, 15'd10000, 15'd25000, 15'd32767,
                    15'd0, 15'd17271, 15'd0, 15'd0};
        phase_b = '{dpm_pkg::B_RESET, 15'd20000, 15'd30000, 15'd0,
                    15'd32767, 15'd8193, 15'd0, 15'd0};
        phase_a[6] = 15'($urandom_range(10000, 25000));
        phase_b[6] = 15'($urandom_range(20000, 30000));
        phase_a[7] = 15'($urandom);
        phase_b[7] = 15'($urandom);

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                drain();
                apb_write({dpm_pkg::REG_IDX_A, 2'b00}, 32'(phase_a[ph]));
                apb_write({dpm_pkg::REG_IDX_B, 2'b00}, 32'(phase_b[ph]));
            end
            if (ph == 0 || ph == 3 || ph == 5) begin
                foreach (dir_rows[i])
                    put_reading(dir_rows[i]);
            end
            // Bursts of random length, mostly separated by random gaps
            burst = $urandom_range(1, 30);
            repeat (240) begin
                put_reading(random_reading());
                burst--;
                if (burst == 0) begin
                    if ($urandom_range(0, 2) != 0)
                        drop_valid($urandom_range(1, 6));
                    burst = $urandom_range(1, 30);
                end
            end
        end

        drop_valid(1);
        while (dew_pending.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
sv/dpm_pkg.sv
sv/dpm_div.sv
sv/dew_point_magnus.sv
sv/dpm_checker.sv
tb/dew_point_magnus_test.sv
